>>> rtl/csv_stream_tokenizer_defines.svh
// Assertion macros shared by the checker of the CSV stream tokeniser.
`ifndef CSV_STREAM_TOKENIZER_DEFINES_SVH
`define CSV_STREAM_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSVT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv tokeniser check failed");

// Next-cycle implication, checked outside reset.
`define CSVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv tokeniser check failed");

// Next-cycle implication that is also checked across reset.
`define CSVT_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("csv tokeniser check failed");

`endif

>>> rtl/csvt_pkg.sv
// Types and constants shared by the CSV stream tokeniser modules.
package csvt_pkg;

   localparam int UNIT_BITS = 16;
   localparam logic [15:0] UNIT_MASK = 16'((17'd1 << UNIT_BITS) - 17'd1);

   localparam logic [15:0] CH_LF    = 16'h000A;
   localparam logic [15:0] CH_CR    = 16'h000D;
   localparam logic [15:0] CH_QUOTE = 16'h0022;
   localparam logic [15:0] CH_COMMA = 16'h002C;

   localparam logic KIND_UNIT  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      EV_DATA = 2'd0,
      EV_CELL = 2'd1,
      EV_ROW  = 2'd2
   } ev_type;

   typedef struct packed {
      logic [1:0]  count;
      ev_type      ev0;
      ev_type      ev1;
      ev_type      ev2;
      logic [15:0] data;
   } evlist_type;

endpackage

>>> rtl/csvt_core.sv
// Tokeniser state and the event list that one accepted item produces.
module csvt_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   kind,
   input  logic [15:0]            unit,
   output csvt_pkg::evlist_type   events
);
   import csvt_pkg::*;

   logic quote_pending_ff, quote_pending_in;
   logic in_quotes_ff, in_quotes_in;
   logic cr_pending_ff, cr_pending_in;
   logic cell_has_data_ff, cell_has_data_in;
   logic row_has_cells_ff, row_has_cells_in;

   always_comb begin
      ev_type      slot [3];
      logic [1:0]  n;
      logic [15:0] c;
      logic        qp, iq, cr, chd, rhc, done;

      slot[0] = EV_DATA;
      slot[1] = EV_DATA;
      slot[2] = EV_DATA;
      n       = 2'd0;
      c       = unit & UNIT_MASK;
      qp      = quote_pending_ff;
      iq      = in_quotes_ff;
      cr      = cr_pending_ff;
      chd     = cell_has_data_ff;
      rhc     = row_has_cells_ff;
      done    = 1'b0;

      if (kind == KIND_FLUSH) begin
         if (chd) begin
            slot[n] = EV_CELL;
            n = n + 2'd1;
            rhc = 1'b1;
         end
         if (rhc) begin
            slot[n] = EV_ROW;
            n = n + 2'd1;
         end
         qp  = 1'b0;
         iq  = 1'b0;
         cr  = 1'b0;
         chd = 1'b0;
         rhc = 1'b0;
      end else begin
         if (qp && c != CH_QUOTE) begin
            iq = ~iq;
            qp = 1'b0;
         end
         if (c == CH_LF) begin
            if (!iq) begin
               if (chd) begin
                  slot[n] = EV_CELL;
                  n = n + 2'd1;
                  chd = 1'b0;
               end
               slot[n] = EV_ROW;
               n = n + 2'd1;
               rhc  = 1'b0;
               cr   = 1'b0;
               done = 1'b1;
            end
         end else if (c == CH_CR) begin
            if (!iq) begin
               if (cr) begin
                  if (chd) begin
                     slot[n] = EV_CELL;
                     n = n + 2'd1;
                     chd = 1'b0;
                  end
                  slot[n] = EV_ROW;
                  n = n + 2'd1;
                  rhc = 1'b0;
               end
               cr   = 1'b1;
               done = 1'b1;
            end
         end else begin
            if (cr) begin
               if (chd) begin
                  slot[n] = EV_CELL;
                  n = n + 2'd1;
                  chd = 1'b0;
               end
               slot[n] = EV_ROW;
               n = n + 2'd1;
               rhc = 1'b0;
            end
            cr = 1'b0;
         end
         if (!done && c == CH_QUOTE) begin
            if (qp) begin
               qp = 1'b0;
            end else begin
               qp   = 1'b1;
               done = 1'b1;
            end
         end
         if (!done && c == CH_COMMA && !iq) begin
            slot[n] = EV_CELL;
            n = n + 2'd1;
            chd  = 1'b0;
            rhc  = 1'b1;
            done = 1'b1;
         end
         if (!done) begin
            slot[n] = EV_DATA;
            n = n + 2'd1;
            chd = 1'b1;
         end
      end

      events.count = n;
      events.ev0   = slot[0];
      events.ev1   = slot[1];
      events.ev2   = slot[2];
      events.data  = c;

      quote_pending_in = qp;
      in_quotes_in     = iq;
      cr_pending_in    = cr;
      cell_has_data_in = chd;
      row_has_cells_in = rhc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_pending_ff <= 1'b0;
         in_quotes_ff     <= 1'b0;
         cr_pending_ff    <= 1'b0;
         cell_has_data_ff <= 1'b0;
         row_has_cells_ff <= 1'b0;
      end else if (accept) begin
         quote_pending_ff <= quote_pending_in;
         in_quotes_ff     <= in_quotes_in;
         cr_pending_ff    <= cr_pending_in;
         cell_has_data_ff <= cell_has_data_in;
         row_has_cells_ff <= row_has_cells_in;
      end
   end

endmodule

>>> rtl/csvt_out.sv
// Result register that holds the events of one item and hands them out one by one.
module csvt_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  csvt_pkg::evlist_type  events,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_event_res,
   output logic [15:0]           rsp_data_unit,
   output logic                  rsp_run_last
);
   import csvt_pkg::*;

   ev_type      ev_ff [3];
   ev_type      ev_in [3];
   logic [15:0] data_ff, data_in;
   logic [1:0]  rem_ff, rem_in;
   logic [1:0]  ptr_ff, ptr_in;
   ev_type      cur_ev;
   logic        take;

   assign cur_ev        = ev_ff[ptr_ff];
   assign rsp_valid     = (rem_ff != 2'd0);
   assign rsp_run_last  = (rem_ff == 2'd1);
   assign rsp_event_res = cur_ev;
   assign rsp_data_unit = (cur_ev == EV_DATA) ? data_ff : 16'd0;
   assign take          = rsp_valid && rsp_ready;
   assign can_load      = (rem_ff == 2'd0) || (rsp_run_last && rsp_ready);

   always_comb begin
      ev_in   = ev_ff;
      data_in = data_ff;
      rem_in  = rem_ff;
      ptr_in  = ptr_ff;
      if (load) begin
         ev_in[0] = events.ev0;
         ev_in[1] = events.ev1;
         ev_in[2] = events.ev2;
         data_in  = events.data;
         rem_in   = events.count;
         ptr_in   = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 2'd1;
         ptr_in = ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         ptr_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      data_ff <= data_in;
   end

endmodule

>>> rtl/csv_stream_tokenizer.sv
// Top level of the CSV stream tokeniser.
// An item is taken in every cycle as long as each item gives at most one event and
// rsp_ready is high; its events appear on the result port from the cycle after it is
// taken. An item that gives k events (up to three) holds the single result register
// until all k have left, one event per cycle while rsp_ready is high, and the next item
// is taken in the cycle its last event leaves. Items that give no event leave it empty.
module csv_stream_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [15:0] rsp_data_unit,
   output logic        rsp_run_last
);
   import csvt_pkg::*;

   evlist_type events;
   logic       accept;

   assign accept = req_valid && req_ready;

   csvt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .unit   (req_unit),
      .events (events)
   );

   csvt_out u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .events        (events),
      .can_load      (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_data_unit (rsp_data_unit),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

>>> rtl/csvt_checker.sv
// Port-level checks for the CSV stream tokeniser and their binding to it.
`include "csv_stream_tokenizer_defines.svh"

module csvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic [15:0] req_unit,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_res,
   input logic [15:0] rsp_data_unit,
   input logic        rsp_run_last
);
   import csvt_pkg::*;

   `CSVT_ASSERT_ALWAYS_NEXT(a_reset_clears_output, clock, reset, !rsp_valid)
   `CSVT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res) && $stable(rsp_data_unit) && $stable(rsp_run_last))
   `CSVT_ASSERT_NOW(a_marker_zero_data, clock, reset, rsp_valid && rsp_event_res != EV_DATA, rsp_data_unit == 16'd0)
   `CSVT_ASSERT_NOW(a_ready_only_when_drained, clock, reset, !req_ready, rsp_valid && !(rsp_run_last && rsp_ready))

endmodule

bind csv_stream_tokenizer csvt_checker u_csvt_checker (.*);
